FILE: sv/wqte_pkg.sv
// ----------------------------------------------------------------------------
// wqte_pkg
// Shared types, operation codes and control/status structs of the wait queue
// timeout engine.
// ----------------------------------------------------------------------------
package wqte_pkg;

    // operation codes
    localparam logic [2:0] OP_WAIT      = 3'd0;
    localparam logic [2:0] OP_WAIT_TO   = 3'd1;
    localparam logic [2:0] OP_WAKE_ONE  = 3'd2;
    localparam logic [2:0] OP_WAKE_ALL  = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_ACCEPT  = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_WAKE    = 2'd2;
    localparam logic [1:0] KIND_TIMEOUT = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  queue_id;
        logic [7:0]  task_id;
        logic [31:0] timeout_ticks;
        logic [31:0] now_tick;
    } in_word_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] woken_task;
        logic [5:0] slot;
        logic       last;
    } out_word_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_AL_RD,
        S_AL_EV,
        S_AL_HEAD,
        S_AL_WRD,
        S_AL_WEV,
        S_AL_OUT,
        S_AL_FULL,
        S_WK_RD,
        S_WK_EV,
        S_TK_RD,
        S_TK_EV,
        S_TK_HEAD,
        S_TK_PRD,
        S_TK_PEV,
        S_TK_PEND,
        S_TK_NEXT,
        S_TK_END
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD, IDX_CLR, IDX_INC, IDX_HEAD, IDX_LINK, IDX_ENT
    } idx_op_t;

    typedef enum logic [2:0] {
        WR_NONE, WR_CLEAR, WR_NEW, WR_FREE, WR_LINK_ENT, WR_LINK_VLINK
    } wr_op_t;

    typedef enum logic [1:0] {
        HEAD_NONE, HEAD_ENT, HEAD_LINK, HEAD_VLINK
    } head_op_t;

    typedef enum logic [1:0] {
        PEND_NONE, PEND_LOAD, PEND_CLR
    } pend_op_t;

    typedef enum logic [2:0] {
        OUT_NONE, OUT_ALLOC, OUT_FULL, OUT_WAKE, OUT_PEND_MID, OUT_PEND_LAST
    } out_op_t;

    typedef struct packed {
        logic     ld_item;
        idx_op_t  idx_op;
        logic     rd;
        wr_op_t   wr_op;
        head_op_t head_op;
        logic     save_e;
        logic     save_v;
        pend_op_t pend_op;
        out_op_t  out_op;
    } cmd_t;

    typedef struct packed {
        logic used;
        logic link_end;
        logic link_is_ent;
        logic head_empty;
        logic head_is_ent;
        logic idx_last;
        logic expired;
        logic op_wait;
        logic op_wake;
        logic op_tick;
        logic wake_one;
        logic out_free;
        logic pend_valid;
    } sts_t;

endpackage

FILE: sv/wqte_dpath.sv
// ----------------------------------------------------------------------------
// wqte_dpath
// Entry pool memory, queue head registers, cursor, pending timeout result and
// output word register.
// ----------------------------------------------------------------------------
module wqte_dpath #(
    parameter int POOL_ENTRIES = 64,
    parameter int QUEUE_COUNT  = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  wqte_pkg::cmd_t    cmd,
    output wqte_pkg::sts_t    sts,
    input  wqte_pkg::in_word_t in_data,
    output wqte_pkg::out_word_t out_data,
    output logic              out_valid,
    input  logic              out_ready
);

    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam int QN = (QUEUE_COUNT < 8) ? QUEUE_COUNT : 8;
    localparam int QW = (QN > 1) ? $clog2(QN) : 1;
    localparam logic [LW-1:0] NO_ENTRY = LW'(POOL_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(POOL_ENTRIES - 1);

    typedef struct packed {
        logic          used;
        logic [LW-1:0] link;
        logic [7:0]    task_id;
        logic [31:0]   deadline;
        logic [QW-1:0] queue;
    } rec_t;

    rec_t          mem [POOL_ENTRIES];
    rec_t          rdata_reg;
    rec_t          wr_rec;
    logic          wr_en;

    logic [2:0]    op_reg;
    logic [2:0]    q_reg;
    logic [7:0]    task_reg;
    logic [31:0]   dl_reg;
    logic [31:0]   now_reg;
    logic [AW-1:0] idx_reg;
    logic [AW-1:0] idx_next;
    logic [AW-1:0] ent_reg;
    logic [LW-1:0] vlink_reg;
    logic [7:0]    vtask_reg;
    logic [LW-1:0] head_reg [QN];
    logic [LW-1:0] head_sel;
    logic          pend_valid_reg;
    logic [7:0]    pend_task_reg;
    logic [AW-1:0] pend_slot_reg;
    logic          out_valid_reg;
    wqte_pkg::out_word_t out_reg;
    logic [32:0]   dl_sum;
    logic          q_ok;

    // saturating deadline
    assign dl_sum = {1'b0, in_data.now_tick} + {1'b0, in_data.timeout_ticks};

    // capture the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            op_reg   <= in_data.operation;
            q_reg    <= in_data.queue_id;
            task_reg <= in_data.task_id;
            now_reg  <= in_data.now_tick;
            if (in_data.operation == wqte_pkg::OP_WAIT_TO)
                dl_reg <= dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];
            else
                dl_reg <= 32'd0;
        end
        else if (cmd.save_v)
        begin
            q_reg <= 3'(rdata_reg.queue);
        end
        if (cmd.save_e || cmd.save_v)
            ent_reg <= idx_reg;
        if (cmd.save_v)
        begin
            vlink_reg <= rdata_reg.link;
            vtask_reg <= rdata_reg.task_id;
        end
    end

    // cursor
    always_comb
    begin
        case (cmd.idx_op)
            wqte_pkg::IDX_CLR:  idx_next = '0;
            wqte_pkg::IDX_INC:  idx_next = idx_reg + 1'b1;
            wqte_pkg::IDX_HEAD: idx_next = head_sel[AW-1:0];
            wqte_pkg::IDX_LINK: idx_next = rdata_reg.link[AW-1:0];
            wqte_pkg::IDX_ENT:  idx_next = ent_reg;
            default:            idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

    // entry write data
    always_comb
    begin
        wr_rec = rdata_reg;
        wr_en  = 1'b1;
        case (cmd.wr_op)
            wqte_pkg::WR_CLEAR:
                wr_rec = '0;
            wqte_pkg::WR_NEW:
            begin
                wr_rec.used     = 1'b1;
                wr_rec.link     = NO_ENTRY;
                wr_rec.task_id  = task_reg;
                wr_rec.deadline = dl_reg;
                wr_rec.queue    = q_reg[QW-1:0];
            end
            wqte_pkg::WR_FREE:       wr_rec.used = 1'b0;
            wqte_pkg::WR_LINK_ENT:   wr_rec.link = LW'(ent_reg);
            wqte_pkg::WR_LINK_VLINK: wr_rec.link = vlink_reg;
            default:                 wr_en = 1'b0;
        endcase
    end

    // entry pool memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg] <= wr_rec;
        if (cmd.rd)
            rdata_reg <= mem[idx_reg];
    end

    // queue heads
    assign head_sel = head_reg[q_reg[QW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QN; i++)
                head_reg[i] <= NO_ENTRY;
        end
        else
        begin
            case (cmd.head_op)
                wqte_pkg::HEAD_ENT:   head_reg[q_reg[QW-1:0]] <= LW'(ent_reg);
                wqte_pkg::HEAD_LINK:  head_reg[q_reg[QW-1:0]] <= rdata_reg.link;
                wqte_pkg::HEAD_VLINK: head_reg[q_reg[QW-1:0]] <= vlink_reg;
                default:              ;
            endcase
        end
    end

    // pending timeout result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (cmd.pend_op == wqte_pkg::PEND_LOAD)
            pend_valid_reg <= 1'b1;
        else if (cmd.pend_op == wqte_pkg::PEND_CLR)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pend_op == wqte_pkg::PEND_LOAD)
        begin
            pend_task_reg <= vtask_reg;
            pend_slot_reg <= ent_reg;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_op != wqte_pkg::OUT_NONE)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.out_op)
            wqte_pkg::OUT_ALLOC:
                out_reg <= '{wqte_pkg::KIND_ACCEPT, task_reg, 6'(ent_reg), 1'b1};
            wqte_pkg::OUT_FULL:
                out_reg <= '{wqte_pkg::KIND_FULL, task_reg, 6'd0, 1'b1};
            wqte_pkg::OUT_WAKE:
                out_reg <= '{wqte_pkg::KIND_WAKE, rdata_reg.task_id, 6'(idx_reg),
                             (op_reg == wqte_pkg::OP_WAKE_ONE) ||
                             (rdata_reg.link == NO_ENTRY)};
            wqte_pkg::OUT_PEND_MID:
                out_reg <= '{wqte_pkg::KIND_TIMEOUT, pend_task_reg,
                             6'(pend_slot_reg), 1'b0};
            wqte_pkg::OUT_PEND_LAST:
                out_reg <= '{wqte_pkg::KIND_TIMEOUT, pend_task_reg,
                             6'(pend_slot_reg), 1'b1};
            default: ;
        endcase
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

    // status toward the controller
    assign q_ok = ({29'd0, q_reg} < 32'(QUEUE_COUNT));

    always_comb
    begin
        sts.used        = rdata_reg.used;
        sts.link_end    = (rdata_reg.link == NO_ENTRY);
        sts.link_is_ent = (rdata_reg.link == LW'(ent_reg));
        sts.head_empty  = (head_sel == NO_ENTRY);
        sts.head_is_ent = (head_sel == LW'(ent_reg));
        sts.idx_last    = (idx_reg == LAST_IDX);
        sts.expired     = rdata_reg.used && (rdata_reg.deadline != 32'd0) &&
                          (now_reg >= rdata_reg.deadline);
        sts.op_wait     = q_ok && ((op_reg == wqte_pkg::OP_WAIT) ||
                                   (op_reg == wqte_pkg::OP_WAIT_TO));
        sts.op_wake     = q_ok && ((op_reg == wqte_pkg::OP_WAKE_ONE) ||
                                   (op_reg == wqte_pkg::OP_WAKE_ALL));
        sts.op_tick     = (op_reg == wqte_pkg::OP_TICK);
        sts.wake_one    = (op_reg == wqte_pkg::OP_WAKE_ONE);
        sts.out_free    = !out_valid_reg || out_ready;
        sts.pend_valid  = pend_valid_reg;
    end

endmodule

FILE: sv/wqte_ctrl.sv
// ----------------------------------------------------------------------------
// wqte_ctrl
// Sequencer for the clearing pass, allocation, wake and tick scans.
// ----------------------------------------------------------------------------
module wqte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  wqte_pkg::sts_t sts,
    output wqte_pkg::cmd_t cmd
);

    wqte_pkg::state_t state_reg;
    wqte_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= wqte_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            wqte_pkg::S_CLEAR:
            begin
                cmd.wr_op  = wqte_pkg::WR_CLEAR;
                cmd.idx_op = wqte_pkg::IDX_INC;
                if (sts.idx_last)
                begin
                    cmd.idx_op = wqte_pkg::IDX_CLR;
                    state_next = wqte_pkg::S_IDLE;
                end
            end
            wqte_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.ld_item = 1'b1;
                    cmd.idx_op  = wqte_pkg::IDX_CLR;
                    state_next  = wqte_pkg::S_DECODE;
                end
            end
            wqte_pkg::S_DECODE:
            begin
                if (sts.op_tick)
                    state_next = wqte_pkg::S_TK_RD;
                else if (sts.op_wait)
                    state_next = wqte_pkg::S_AL_RD;
                else if (sts.op_wake && !sts.head_empty)
                begin
                    cmd.idx_op = wqte_pkg::IDX_HEAD;
                    state_next = wqte_pkg::S_WK_RD;
                end
                else
                    state_next = wqte_pkg::S_IDLE;
            end
            // find the lowest free entry
            wqte_pkg::S_AL_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = wqte_pkg::S_AL_EV;
            end
            wqte_pkg::S_AL_EV:
            begin
                if (!sts.used)
                begin
                    cmd.save_e = 1'b1;
                    cmd.wr_op  = wqte_pkg::WR_NEW;
                    state_next = wqte_pkg::S_AL_HEAD;
                end
                else if (sts.idx_last)
                    state_next = wqte_pkg::S_AL_FULL;
                else
                begin
                    cmd.idx_op = wqte_pkg::IDX_INC;
                    state_next = wqte_pkg::S_AL_RD;
                end
            end
            // append at the queue tail
            wqte_pkg::S_AL_HEAD:
            begin
                if (sts.head_empty)
                begin
                    cmd.head_op = wqte_pkg::HEAD_ENT;
                    state_next  = wqte_pkg::S_AL_OUT;
                end
                else
                begin
                    cmd.idx_op = wqte_pkg::IDX_HEAD;
                    state_next = wqte_pkg::S_AL_WRD;
                end
            end
            wqte_pkg::S_AL_WRD:
            begin
                cmd.rd     = 1'b1;
                state_next = wqte_pkg::S_AL_WEV;
            end
            wqte_pkg::S_AL_WEV:
            begin
                if (sts.link_end)
                begin
                    cmd.wr_op  = wqte_pkg::WR_LINK_ENT;
                    state_next = wqte_pkg::S_AL_OUT;
                end
                else
                begin
                    cmd.idx_op = wqte_pkg::IDX_LINK;
                    state_next = wqte_pkg::S_AL_WRD;
                end
            end
            wqte_pkg::S_AL_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_op = wqte_pkg::OUT_ALLOC;
                    state_next = wqte_pkg::S_IDLE;
                end
            end
            wqte_pkg::S_AL_FULL:
            begin
                if (sts.out_free)
                begin
                    cmd.out_op = wqte_pkg::OUT_FULL;
                    state_next = wqte_pkg::S_IDLE;
                end
            end
            // pop from the queue head
            wqte_pkg::S_WK_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = wqte_pkg::S_WK_EV;
            end
            wqte_pkg::S_WK_EV:
            begin
                if (sts.out_free)
                begin
                    cmd.head_op = wqte_pkg::HEAD_LINK;
                    cmd.wr_op   = wqte_pkg::WR_FREE;
                    cmd.out_op  = wqte_pkg::OUT_WAKE;
                    if (sts.wake_one || sts.link_end)
                        state_next = wqte_pkg::S_IDLE;
                    else
                    begin
                        cmd.idx_op = wqte_pkg::IDX_LINK;
                        state_next = wqte_pkg::S_WK_RD;
                    end
                end
            end
            // scan for expired deadlines
            wqte_pkg::S_TK_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = wqte_pkg::S_TK_EV;
            end
            wqte_pkg::S_TK_EV:
            begin
                if (sts.expired)
                begin
                    cmd.save_v = 1'b1;
                    cmd.wr_op  = wqte_pkg::WR_FREE;
                    state_next = wqte_pkg::S_TK_HEAD;
                end
                else if (sts.idx_last)
                    state_next = wqte_pkg::S_TK_END;
                else
                begin
                    cmd.idx_op = wqte_pkg::IDX_INC;
                    state_next = wqte_pkg::S_TK_RD;
                end
            end
            // unlink the expired entry from its queue
            wqte_pkg::S_TK_HEAD:
            begin
                if (sts.head_empty)
                    state_next = wqte_pkg::S_TK_PEND;
                else if (sts.head_is_ent)
                begin
                    cmd.head_op = wqte_pkg::HEAD_VLINK;
                    state_next  = wqte_pkg::S_TK_PEND;
                end
                else
                begin
                    cmd.idx_op = wqte_pkg::IDX_HEAD;
                    state_next = wqte_pkg::S_TK_PRD;
                end
            end
            wqte_pkg::S_TK_PRD:
            begin
                cmd.rd     = 1'b1;
                state_next = wqte_pkg::S_TK_PEV;
            end
            wqte_pkg::S_TK_PEV:
            begin
                if (sts.link_is_ent)
                begin
                    cmd.wr_op  = wqte_pkg::WR_LINK_VLINK;
                    state_next = wqte_pkg::S_TK_PEND;
                end
                else if (sts.link_end)
                    state_next = wqte_pkg::S_TK_PEND;
                else
                begin
                    cmd.idx_op = wqte_pkg::IDX_LINK;
                    state_next = wqte_pkg::S_TK_PRD;
                end
            end
            // hold one result back so the final one can be marked
            wqte_pkg::S_TK_PEND:
            begin
                if (!sts.pend_valid)
                begin
                    cmd.pend_op = wqte_pkg::PEND_LOAD;
                    cmd.idx_op  = wqte_pkg::IDX_ENT;
                    state_next  = wqte_pkg::S_TK_NEXT;
                end
                else if (sts.out_free)
                begin
                    cmd.out_op  = wqte_pkg::OUT_PEND_MID;
                    cmd.pend_op = wqte_pkg::PEND_LOAD;
                    cmd.idx_op  = wqte_pkg::IDX_ENT;
                    state_next  = wqte_pkg::S_TK_NEXT;
                end
            end
            wqte_pkg::S_TK_NEXT:
            begin
                if (sts.idx_last)
                    state_next = wqte_pkg::S_TK_END;
                else
                begin
                    cmd.idx_op = wqte_pkg::IDX_INC;
                    state_next = wqte_pkg::S_TK_RD;
                end
            end
            wqte_pkg::S_TK_END:
            begin
                if (!sts.pend_valid)
                    state_next = wqte_pkg::S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.out_op  = wqte_pkg::OUT_PEND_LAST;
                    cmd.pend_op = wqte_pkg::PEND_CLR;
                    state_next  = wqte_pkg::S_IDLE;
                end
            end
            default:
                state_next = wqte_pkg::S_IDLE;
        endcase
    end

endmodule

FILE: sv/wait_queue_timeout_engine.sv
// ----------------------------------------------------------------------------
// wait_queue_timeout_engine
// Wait queues over a shared entry pool, with wake-one, wake-all and timeouts.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_ready is high only while the engine is idle,
// and a finished result can sit in the output register while the next word is
// taken. After reset the engine runs a clearing pass over all POOL_ENTRIES
// entries before it accepts a word. All entry state lives in one single-port-read
// pool memory, and each entry visit is a read step followed by an evaluate step:
// a wait scans up from entry 0 for the lowest free entry and then walks the
// target queue to its tail; a wake-one pops the queue head and a wake-all pops
// every waiter in turn; a tick visits every pool entry and walks the queue of
// each expired waiter to unlink it. Results are delivered in order and the last
// result of a word carries last = 1; waits on an invalid queue, unknown
// operations, wakes on an empty queue and ticks with nothing expired give no
// result.
module wait_queue_timeout_engine #(
    parameter int POOL_ENTRIES = 64,
    parameter int QUEUE_COUNT  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  wqte_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output wqte_pkg::out_word_t out_data
);

    wqte_pkg::cmd_t cmd;
    wqte_pkg::sts_t sts;

    // sequencer
    wqte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // pool, heads and output register
    wqte_dpath #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .QUEUE_COUNT  (QUEUE_COUNT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

FILE: verif/wait_queue_timeout_engine_tb.sv
// ----------------------------------------------------------------------------
// wait_queue_timeout_engine_tb
// Drives waits, timed waits, wakes and ticks into the wait queue engine and
// checks every result word against a built-in model of the entry pool and
// its linked queues, with random idling on both handshakes.
// ----------------------------------------------------------------------------
module wait_queue_timeout_engine_tb;

    localparam int ENTRIES = 64;
    localparam int QUEUES  = 8;
    localparam int NONE    = ENTRIES;

    // reserved operation codes, ignored by the engine
    localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    wqte_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    wqte_pkg::out_word_t out_data;

    wait_queue_timeout_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // pool mirror
    bit          ent_used [ENTRIES];
    int          ent_next [ENTRIES];
    logic [7:0]  ent_task [ENTRIES];
    logic [31:0] ent_dl   [ENTRIES];
    int          ent_q    [ENTRIES];
    int          q_head   [QUEUES];

    wqte_pkg::out_word_t pending_words[$];
    int          errors;
    int          word_count;
    int          result_count;
    int          timeout_count;
    bit          idle_on;
    logic [31:0] clock_now;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #200000000;
        $display("wait_queue_timeout_engine_tb failed");
        $finish;
    end

    function automatic void push_word(logic [1:0] k, logic [7:0] t, int s);
        wqte_pkg::out_word_t w;
        w.kind       = k;
        w.woken_task = t;
        w.slot       = s[5:0];
        w.last       = 1'b0;
        pending_words.push_back(w);
    endfunction

    function automatic void drop_from_queue(int q, int e);
        int p;
        if (q_head[q] == NONE)
            return;
        if (q_head[q] == e)
        begin
            q_head[q] = ent_next[e];
            return;
        end
        p = q_head[q];
        while (p != NONE && ent_next[p] != e)
            p = ent_next[p];
        if (p != NONE)
            ent_next[p] = ent_next[e];
    endfunction

    // compute the result words of one accepted word
    function automatic void predict_words(wqte_pkg::in_word_t w);
        int          start_size;
        int          e;
        int          c;
        logic [32:0] sum;
        start_size = pending_words.size();
        if (w.operation == wqte_pkg::OP_TICK)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (ent_used[i] && ent_dl[i] != 0 && w.now_tick >= ent_dl[i])
                begin
                    drop_from_queue(ent_q[i], i);
                    ent_used[i] = 0;
                    push_word(wqte_pkg::KIND_TIMEOUT, ent_task[i], i);
                    timeout_count++;
                end
            end
        end
        else if (w.operation == wqte_pkg::OP_WAIT || w.operation == wqte_pkg::OP_WAIT_TO)
        begin
            e = NONE;
            for (int i = 0; i < ENTRIES; i++)
                if (!ent_used[i] && e == NONE)
                    e = i;
            if (e == NONE)
                push_word(wqte_pkg::KIND_FULL, w.task_id, 0);
            else
            begin
                sum = {1'b0, w.now_tick} + {1'b0, w.timeout_ticks};
                ent_used[e] = 1;
                ent_task[e] = w.task_id;
                ent_dl[e]   = (w.operation == wqte_pkg::OP_WAIT) ? 32'd0 :
                              (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
                ent_q[e]    = int'(w.queue_id);
                ent_next[e] = NONE;
                if (q_head[w.queue_id] == NONE)
                    q_head[w.queue_id] = e;
                else
                begin
                    c = q_head[w.queue_id];
                    while (ent_next[c] != NONE)
                        c = ent_next[c];
                    ent_next[c] = e;
                end
                push_word(wqte_pkg::KIND_ACCEPT, w.task_id, e);
            end
        end
        else if (w.operation == wqte_pkg::OP_WAKE_ONE ||
                 w.operation == wqte_pkg::OP_WAKE_ALL)
        begin
            while (q_head[w.queue_id] != NONE)
            begin
                e = q_head[w.queue_id];
                q_head[w.queue_id] = ent_next[e];
                ent_used[e] = 0;
                push_word(wqte_pkg::KIND_WAKE, ent_task[e], e);
                if (w.operation == wqte_pkg::OP_WAKE_ONE)
                    break;
            end
        end
        if (pending_words.size() > start_size)
            pending_words[pending_words.size() - 1].last = 1'b1;
    endfunction

    // send one word, with an optional idle burst ahead of it
    task automatic send_word(logic [2:0] op, int q, logic [7:0] t,
                             logic [31:0] ticks, logic [31:0] now_val);
        wqte_pkg::in_word_t w;
        w.operation     = op;
        w.queue_id      = q[2:0];
        w.task_id       = t;
        w.timeout_ticks = ticks;
        w.now_tick      = now_val;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_words(w);
        word_count++;
    endtask

    // drop valid and wait until every expected word has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // receiver stalls
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // check each accepted result word
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %p", $time, out_data);
            end
            else
            begin
                if (out_data !== pending_words[0])
                begin
                    errors++;
                    $display("%0t: mismatch, expected %p, actual %p",
                             $time, pending_words[0], out_data);
                end
                void'(pending_words.pop_front());
            end
        end
    end

    task automatic test_directed();
        send_word(wqte_pkg::OP_WAKE_ONE, 0, 8'h00, 32'd0, 32'd0);
        send_word(wqte_pkg::OP_TICK, 0, 8'h00, 32'd0, 32'd0);
        send_word(wqte_pkg::OP_WAIT, 0, 8'h00, 32'd0, 32'd0);
        send_word(wqte_pkg::OP_WAIT, 0, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(wqte_pkg::OP_WAIT_TO, 7, 8'hA5, 32'hFFFF_FFFF, 32'h10);
        send_word(wqte_pkg::OP_WAIT_TO, 7, 8'h5A, 32'd0, 32'd0);
        send_word(wqte_pkg::OP_WAIT_TO, 3, 8'h11, 32'd5, 32'd10);
        send_word(wqte_pkg::OP_WAIT_TO, 3, 8'h22, 32'd2, 32'd10);
        send_word(OP_UNUSED_FIRST, 1, 8'h33, 32'd1, 32'd1);
        send_word(OP_UNUSED_LAST, 2, 8'hCC, 32'd1, 32'd1);
        send_word(wqte_pkg::OP_TICK, 0, 8'h00, 32'd0, 32'd14);
        send_word(wqte_pkg::OP_TICK, 7, 8'h00, 32'd0, 32'hFFFF_FFFE);
        send_word(wqte_pkg::OP_TICK, 5, 8'h00, 32'd0, 32'hFFFF_FFFF);
        send_word(wqte_pkg::OP_WAKE_ONE, 0, 8'h00, 32'd0, 32'd0);
        send_word(wqte_pkg::OP_WAKE_ALL, 0, 8'h00, 32'd0, 32'd0);
        send_word(wqte_pkg::OP_WAKE_ALL, 7, 8'h00, 32'd0, 32'd0);
        clock_now = 32'd100;
    endtask

    task automatic test_pool_full();
        for (int i = 0; i < ENTRIES + 2; i++)
            send_word(wqte_pkg::OP_WAIT, i % QUEUES, i[7:0], 32'd0, clock_now);
        wait_drained();
        for (int q = 0; q < QUEUES; q++)
            send_word(wqte_pkg::OP_WAKE_ALL, q, 8'h00, 32'd0, clock_now);
    endtask

    // random traffic, including reserved operation codes, with an advancing clock
    task automatic test_random(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                send_word(3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)),
                          $urandom_range(0, 7), 8'($urandom), $urandom, $urandom);
            else if (r < 30)
                send_word(wqte_pkg::OP_WAIT, $urandom_range(0, 7), 8'($urandom),
                          $urandom, clock_now);
            else if (r < 60)
                send_word(wqte_pkg::OP_WAIT_TO, $urandom_range(0, 7), 8'($urandom),
                          (r < 33) ? $urandom : $urandom_range(0, 40), clock_now);
            else if (r < 75)
                send_word(wqte_pkg::OP_WAKE_ONE, $urandom_range(0, 7), 8'($urandom),
                          $urandom, clock_now);
            else if (r < 82)
                send_word(wqte_pkg::OP_WAKE_ALL, $urandom_range(0, 7), 8'($urandom),
                          $urandom, clock_now);
            else
            begin
                clock_now = clock_now + $urandom_range(0, 15);
                send_word(wqte_pkg::OP_TICK, $urandom_range(0, 7), 8'($urandom),
                          $urandom, clock_now);
            end
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        errors        = 0;
        word_count    = 0;
        result_count  = 0;
        timeout_count = 0;
        idle_on       = 1'b1;
        clock_now     = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            ent_used[i] = 0;
            ent_next[i] = NONE;
            ent_task[i] = 0;
            ent_dl[i]   = 0;
            ent_q[i]    = 0;
        end
        for (int q = 0; q < QUEUES; q++)
            q_head[q] = NONE;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_pool_full();
        test_random(320);
        // hold off until the engine has drained
        wait_drained();
        idle_on = 1'b0;
        test_random(60);

        wait_drained();
        repeat (300) @(posedge clk);
        $display("covered %0d words, %0d results, %0d timeouts, pool full and overflow",
                 word_count, result_count, timeout_count);
        if (errors == 0)
            $display("wait_queue_timeout_engine_tb passed");
        else
            $display("wait_queue_timeout_engine_tb failed");
        $finish;
    end

endmodule
